// ----- hdl/fp32fma_pkg.sv -----
// Package for the binary32 fused multiply-add pipeline.
// Holds the transfer payload types, the pipeline depth and the binary32 constants.
// It has no dependencies.
package fp32fma_pkg;

  localparam int unsigned NUM_STAGES = 7;
  localparam int unsigned EXP_W = 12;

  localparam logic [31:0] DEFAULT_NAN = 32'h7FC0_0000;
  localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;
  localparam logic [31:0] INF_BITS    = 32'h7F80_0000;

  typedef struct packed {
    logic [31:0] multiplicand;
    logic [31:0] multiplier;
    logic [31:0] addend;
    logic        last_in;
  } in_t;

  typedef struct packed {
    logic [31:0] sum_out;
    logic        last_out;
  } out_t;

  typedef struct packed {
    logic        spec;
    logic [31:0] res;
    logic        last;
  } ctl_t;

endpackage

// ----- hdl/fp32_fused_multiply_add.sv -----
// Seven-stage binary32 fused multiply-add with round-to-nearest-even.
// Depends on fp32fma_pkg for the payload types and the binary32 constants.
// Throughput is one transfer per cycle while the output is not stalled; every stage has its own valid bit
// and holds only while the stage after it is full and held, so bubbles close up.
// The asynchronous active-low reset clears the valid bits only.
module fp32_fused_multiply_add import fp32fma_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  function automatic logic [5:0] lead48(input logic [47:0] x);
    logic [5:0] n;
    n = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (x[i]) n = 6'(47 - i);
    end
    return n;
  endfunction

  function automatic logic [5:0] top63(input logic [62:0] x);
    logic [5:0] n;
    n = 6'd0;
    for (int i = 0; i < 63; i++) begin
      if (x[i]) n = 6'(i);
    end
    return n;
  endfunction

  logic [NUM_STAGES-1:0] v_q;
  logic [NUM_STAGES-1:0] en;
  ctl_t                  ctl_q [NUM_STAGES-1];
  ctl_t                  ctl1_d, ctl4_d;

  always_comb begin
    en[NUM_STAGES-1] = !v_q[NUM_STAGES-1] || !out_stall_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = v_q[NUM_STAGES-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Stage 1: classify, unpack and multiply.
  logic [31:0] a, b, c;
  logic        nan_a, nan_b, nan_c, inf_a, inf_b, inf_c, zero_a, zero_b, zero_c;
  logic        sp, sc;
  logic [23:0] ma, mb, mc;
  logic signed [EXP_W-1:0] ea, eb, ec;

  assign a = in_data_i.multiplicand;
  assign b = in_data_i.multiplier;
  assign c = in_data_i.addend;
  assign nan_a  = {1'b0, a[30:0]} > INF_BITS;
  assign nan_b  = {1'b0, b[30:0]} > INF_BITS;
  assign nan_c  = {1'b0, c[30:0]} > INF_BITS;
  assign inf_a  = {1'b0, a[30:0]} == INF_BITS;
  assign inf_b  = {1'b0, b[30:0]} == INF_BITS;
  assign inf_c  = {1'b0, c[30:0]} == INF_BITS;
  assign zero_a = a[30:0] == '0;
  assign zero_b = b[30:0] == '0;
  assign zero_c = c[30:0] == '0;
  assign sp = a[31] ^ b[31];
  assign sc = c[31];
  assign ma = {a[30:23] != '0, a[22:0]};
  assign mb = {b[30:23] != '0, b[22:0]};
  assign mc = {c[30:23] != '0, c[22:0]};
  assign ea = (a[30:23] == '0) ? -12'sd149 : $signed({4'b0, a[30:23]}) - 12'sd150;
  assign eb = (b[30:23] == '0) ? -12'sd149 : $signed({4'b0, b[30:23]}) - 12'sd150;
  assign ec = (c[30:23] == '0) ? -12'sd149 : $signed({4'b0, c[30:23]}) - 12'sd150;

  always_comb begin
    ctl1_d.last = in_data_i.last_in;
    ctl1_d.spec = 1'b1;
    ctl1_d.res  = c;
    if (nan_a) begin
      ctl1_d.res = a | QUIET_BIT;
    end else if (nan_b) begin
      ctl1_d.res = b | QUIET_BIT;
    end else if ((inf_a && zero_b) || (zero_a && inf_b)) begin
      ctl1_d.res = DEFAULT_NAN;
    end else if (nan_c) begin
      ctl1_d.res = c | QUIET_BIT;
    end else if (inf_a || inf_b) begin
      ctl1_d.res = (inf_c && (sc != sp)) ? DEFAULT_NAN : {sp, INF_BITS[30:0]};
    end else if (inf_c) begin
      ctl1_d.res = c;
    end else if (zero_a || zero_b) begin
      ctl1_d.res = zero_c ? {sp & sc, 31'b0} : c;
    end else begin
      ctl1_d.spec = 1'b0;
    end
  end

  logic [47:0] p1_q, p2_q;
  logic [23:0] mc1_q, mc2_q;
  logic signed [EXP_W-1:0] ep1_q, ec1_q, ep2_q, ec2_q;
  logic sp1_q, sc1_q, zc1_q, sp2_q, sc2_q, zc2_q;
  logic [5:0] shp2_q, shc2_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      ctl_q[0] <= ctl1_d;
      p1_q     <= ma * mb;
      ep1_q    <= ea + eb;
      mc1_q    <= mc;
      ec1_q    <= ec;
      sp1_q    <= sp;
      sc1_q    <= sc;
      zc1_q    <= zero_c;
    end
  end

  // Stage 2: leading-zero counts of the product and the addend significand.
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      ctl_q[1] <= ctl_q[0];
      p2_q     <= p1_q;
      mc2_q    <= mc1_q;
      ep2_q    <= ep1_q;
      ec2_q    <= ec1_q;
      sp2_q    <= sp1_q;
      sc2_q    <= sc1_q;
      zc2_q    <= zc1_q;
      shp2_q   <= 6'd14 + lead48(p1_q);
      shc2_q   <= 6'd38 + lead48({mc1_q, 24'b0});
    end
  end

  // Stage 3: normalize both operands to bit 61 and order them by magnitude.
  logic [61:0] pn, cn;
  logic signed [EXP_W-1:0] epn, ecn;
  logic swap;
  logic [61:0] big3_q, small3_q;
  logic signed [EXP_W-1:0] e3_q, d3_q;
  logic s3_q, sub3_q;

  assign pn  = {14'b0, p2_q} << shp2_q;
  assign cn  = zc2_q ? '0 : ({38'b0, mc2_q} << shc2_q);
  assign epn = ep2_q - $signed({6'b0, shp2_q});
  assign ecn = ec2_q - $signed({6'b0, shc2_q});
  assign swap = !zc2_q && ((epn < ecn) || ((epn == ecn) && (pn < cn)));

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      ctl_q[2] <= ctl_q[1];
      big3_q   <= swap ? cn : pn;
      small3_q <= swap ? pn : cn;
      e3_q     <= swap ? ecn : epn;
      d3_q     <= zc2_q ? '0 : (swap ? (ecn - epn) : (epn - ecn));
      s3_q     <= swap ? sc2_q : sp2_q;
      sub3_q   <= !zc2_q && (sp2_q != sc2_q);
    end
  end

  // Stage 4: align the smaller operand with a sticky bit, then add or subtract.
  logic [61:0] small_j;
  logic [62:0] sum4;
  logic [62:0] sum4_q;
  logic signed [EXP_W-1:0] e4_q;
  logic s4_q;

  always_comb begin
    if (d3_q > 12'sd63) begin
      small_j = {61'b0, small3_q != '0};
    end else begin
      small_j = (small3_q >> d3_q[5:0]) |
                {61'b0, (small3_q & ((62'd1 << d3_q[5:0]) - 62'd1)) != '0};
    end
    sum4 = sub3_q ? ({1'b0, big3_q} - {1'b0, small_j}) : ({1'b0, big3_q} + {1'b0, small_j});
    ctl4_d = ctl_q[2];
    if (!ctl_q[2].spec && sub3_q && (sum4 == '0)) begin
      ctl4_d.spec = 1'b1;
      ctl4_d.res  = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      ctl_q[3] <= ctl4_d;
      sum4_q   <= sum4;
      e4_q     <= e3_q;
      s4_q     <= s3_q;
    end
  end

  // Stage 5: position of the leading one of the sum.
  logic [62:0] sum5_q;
  logic signed [EXP_W-1:0] e5_q;
  logic s5_q;
  logic [5:0] t5_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      ctl_q[4] <= ctl_q[3];
      sum5_q   <= sum4_q;
      e5_q     <= e4_q;
      s5_q     <= s4_q;
      t5_q     <= top63(sum4_q);
    end
  end

  // Stage 6: rounding position, limited at the subnormal boundary.
  logic signed [EXP_W-1:0] sha, shlim, sh6;
  logic [62:0] sum6_q;
  logic signed [EXP_W-1:0] sh6_q, lsb6_q;
  logic s6_q;

  assign sha   = $signed({6'b0, t5_q}) - 12'sd23;
  assign shlim = -12'sd149 - e5_q;
  assign sh6   = (sha < shlim) ? shlim : sha;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      ctl_q[5] <= ctl_q[4];
      sum6_q   <= sum5_q;
      sh6_q    <= sh6;
      lsb6_q   <= e5_q + sh6;
      s6_q     <= s5_q;
    end
  end

  // Stage 7: round to nearest even and pack.
  logic [24:0] q;
  logic [5:0]  shamt;
  logic [62:0] lsh;
  logic        rnd, sticky;
  logic signed [EXP_W-1:0] lsb7, be7, nsh;
  logic [31:0] res7;

  always_comb begin
    q      = '0;
    shamt  = sh6_q[5:0];
    nsh    = -sh6_q;
    lsh    = sum6_q << nsh[4:0];
    rnd    = 1'b0;
    sticky = 1'b0;
    if (sh6_q <= 12'sd0) begin
      q = lsh[24:0];
    end else if (sh6_q > 12'sd63) begin
      q = '0;
    end else begin
      q      = 25'(sum6_q >> shamt);
      rnd    = sum6_q[shamt - 6'd1];
      sticky = (sum6_q & ((63'd1 << (shamt - 6'd1)) - 63'd1)) != '0;
      if (rnd && (sticky || q[0])) q = q + 25'd1;
    end
    lsb7 = lsb6_q;
    if (q[24]) begin
      q    = q >> 1;
      lsb7 = lsb7 + 12'sd1;
    end
    be7 = lsb7 + 12'sd150;
    if (q[23]) begin
      if (be7 >= 12'sd255) begin
        res7 = {s6_q, INF_BITS[30:0]};
      end else begin
        res7 = {s6_q, be7[7:0], q[22:0]};
      end
    end else begin
      res7 = {s6_q, 8'b0, q[22:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      out_data_o.sum_out  <= ctl_q[5].spec ? ctl_q[5].res : res7;
      out_data_o.last_out <= ctl_q[5].last;
    end
  end

endmodule
